// ===== src/rar_pkg.sv =====
// Package for the rational arithmetic reducer: payload structs, codes, widths.
// No dependencies.
package rar_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
    localparam int MAG_WIDTH     = PROD_WIDTH + 1;
    localparam int CNT_WIDTH     = $clog2(MAG_WIDTH + 1);

    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_SUB = 2'd1;
    localparam logic [1:0] ACT_MUL = 2'd2;
    localparam logic [1:0] ACT_DIV = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIVZERO = 2'd1;
    localparam logic [1:0] ST_ZERODEN = 2'd2;

    typedef struct packed {
        logic [1:0]                      action;
        logic signed [OPERAND_WIDTH-1:0] first_num;
        logic signed [OPERAND_WIDTH-1:0] first_den;
        logic signed [OPERAND_WIDTH-1:0] second_num;
        logic signed [OPERAND_WIDTH-1:0] second_den;
    } t_req;

    typedef struct packed {
        logic signed [31:0] result_num;
        logic signed [31:0] result_den;
        logic [1:0]         status;
    } t_rsp;

endpackage

// ===== src/rational_arith_reduce.sv =====
// Top level of the rational arithmetic reducer: sequencer, shared multiplier,
// adder and the shared divider (rar_divu). Depends on rar_pkg and rar_divu.
//
//  channel | signals                 | direction
//  request | i_valid, o_ready, i_req | in
//  result  | o_valid, i_ready, o_rsp | out
//
// A request passes through the products and the numerator add, the Euclid
// steps of the gcd (start, divider run, remainder load), one last gcd check,
// the two divisions by the gcd and the output load before o_valid. Operand
// faults go straight to the output load. Reset clears the sequencer; o_ready
// is high only in idle, and a result that is not yet taken holds in its output
// register while the next request is worked on.
module rational_arith_reduce (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rar_pkg::t_req   i_req,
    output logic            o_valid,
    input  logic            i_ready,
    output rar_pkg::t_rsp   o_rsp
);
    localparam int OW = rar_pkg::OPERAND_WIDTH;
    localparam int MW = rar_pkg::MAG_WIDTH;
    localparam int PW = rar_pkg::PROD_WIDTH;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_MUL0 = 11'b00000000010,
        S_MUL1 = 11'b00000000100,
        S_ADD  = 11'b00000001000,
        S_GCD  = 11'b00000010000,
        S_GWT  = 11'b00000100000,
        S_DN   = 11'b00001000000,
        S_DNW  = 11'b00010000000,
        S_DD   = 11'b00100000000,
        S_DDW  = 11'b01000000000,
        S_OUT  = 11'b10000000000
    } t_state;

    t_state r_state;
    rar_pkg::t_req r_req;
    logic [MW-1:0] r_p0, r_p1, r_m, r_ga, r_gb, r_nq;
    logic r_s0, r_s1, r_sm;
    logic r_valid;
    rar_pkg::t_rsp r_rsp;

    // signed operand magnitudes
    function automatic logic [OW-1:0] mag(input logic [OW-1:0] v);
        return v[OW-1] ? (~v + 1'b1) : v;
    endfunction

    logic [OW-1:0] ma, mb, mc, md, mx, my;
    logic [PW-1:0] prod;
    logic          sa, sb, sc, sd;
    assign ma = mag(r_req.first_num);  assign sa = r_req.first_num[OW-1];
    assign mb = mag(r_req.first_den);  assign sb = r_req.first_den[OW-1];
    assign mc = mag(r_req.second_num); assign sc = r_req.second_num[OW-1];
    assign md = mag(r_req.second_den); assign sd = r_req.second_den[OW-1];

    // shared multiplier: MUL0 forms numerator term 0, MUL1 term 1, ADD the denominator
    always_comb begin
        unique case (r_state)
            S_MUL0:  begin mx = ma; my = (r_req.action == rar_pkg::ACT_MUL) ? mc : md; end
            S_MUL1:  begin mx = mb; my = mc; end
            default: begin mx = mb; my = (r_req.action == rar_pkg::ACT_DIV) ? mc : md; end
        endcase
    end
    assign prod = mx * my;

    // shared divider
    logic          d_start, d_busy;
    logic [MW-1:0] d_a, d_b, d_q, d_r;
    rar_divu u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(d_start),
        .i_dividend(d_a), .i_divisor(d_b),
        .o_busy(d_busy), .o_quot(d_q), .o_rem(d_r)
    );

    // signed add or subtract of the two numerator terms; MUL and DIV pass term 0
    logic          s1x, num_s;
    logic [MW-1:0] num_m;
    always_comb begin
        s1x = r_s1 ^ (r_req.action == rar_pkg::ACT_SUB);
        if (r_req.action == rar_pkg::ACT_MUL || r_req.action == rar_pkg::ACT_DIV) begin
            num_s = r_s0; num_m = r_p0;
        end else if (r_s0 == s1x) begin
            num_s = r_s0; num_m = r_p0 + r_p1;
        end else if (r_p0 >= r_p1) begin
            num_s = r_s0; num_m = r_p0 - r_p1;
        end else begin
            num_s = s1x;  num_m = r_p1 - r_p0;
        end
    end

    logic n_div_start_gcd;
    assign n_div_start_gcd = (r_state == S_GCD) && (r_gb != '0);

    // divider operands: Euclid step, then numerator and denominator by the gcd
    always_comb begin
        d_start = 1'b0; d_a = r_ga; d_b = r_gb;
        unique case (r_state)
            S_GCD:   d_start = n_div_start_gcd;
            S_DN:    begin d_start = 1'b1; d_a = r_p0; d_b = r_ga; end
            S_DD:    begin d_start = 1'b1; d_a = r_m; d_b = r_ga; end
            default: d_start = 1'b0;
        endcase
    end

    // helper: wrap signed magnitude to 32 bits
    function automatic logic [31:0] wrap(input logic s, input logic [MW-1:0] m);
        return s ? (32'(~m) + 32'd1) : m[31:0];
    endfunction

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && i_ready) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid && o_ready) begin
                    r_req <= i_req;
                    // operand faults skip the arithmetic
                    if (i_req.first_den == '0 || i_req.second_den == '0) begin
                        r_state <= S_OUT;
                    end else if (i_req.action == rar_pkg::ACT_DIV
                                 && i_req.second_num == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MUL0;
                    end
                end
                S_MUL0: begin
                    r_p0 <= MW'(prod);
                    r_s0 <= sa ^ ((r_req.action == rar_pkg::ACT_MUL) ? sc : sd);
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_p1 <= MW'(prod); r_s1 <= sb ^ sc;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_m  <= MW'(prod);
                    r_sm <= sb ^ ((r_req.action == rar_pkg::ACT_DIV) ? sc : sd);
                    r_p0 <= num_m; r_s0 <= num_s;
                    r_ga <= num_m; r_gb <= MW'(prod);
                    r_state <= S_GCD;
                end
                // Euclid: ga,gb <- gb, ga mod gb
                S_GCD: begin
                    if (r_gb == '0) begin
                        r_state <= S_DN;
                    end else begin
                        r_state <= S_GWT;
                    end
                end
                S_GWT: if (!d_busy) begin
                    r_ga <= r_gb; r_gb <= d_r;
                    r_state <= S_GCD;
                end
                // numerator / gcd
                S_DN: r_state <= S_DNW;
                S_DNW: if (!d_busy) begin
                    r_nq <= d_q;
                    r_state <= S_DD;
                end
                // denominator / gcd
                S_DD: r_state <= S_DDW;
                S_DDW: if (!d_busy) begin
                    r_m <= d_q;
                    r_state <= S_OUT;
                end
                // load the output once the previous result is taken
                S_OUT: if (!r_valid) begin
                    r_valid <= 1'b1;
                    priority if (r_req.first_den == '0 || r_req.second_den == '0)
                        r_rsp <= '{32'sd0, 32'sd1, rar_pkg::ST_ZERODEN};
                    else if (r_req.action == rar_pkg::ACT_DIV && r_req.second_num == '0)
                        r_rsp <= '{32'sd0, 32'sd1, rar_pkg::ST_DIVZERO};
                    else
                        r_rsp <= '{wrap(r_s0, r_nq), wrap(r_sm, r_m), rar_pkg::ST_OK};
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;
endmodule

// ===== src/rar_divu.sv =====
// Restoring divider, one quotient bit a cycle, over MAG_WIDTH-bit magnitudes.
// Depends on rar_pkg.
module rar_divu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rar_pkg::MAG_WIDTH-1:0] i_dividend,
    input  logic [rar_pkg::MAG_WIDTH-1:0] i_divisor,
    output logic                          o_busy,
    output logic [rar_pkg::MAG_WIDTH-1:0] o_quot,
    output logic [rar_pkg::MAG_WIDTH-1:0] o_rem
);
    localparam int W = rar_pkg::MAG_WIDTH;

    logic [W-1:0] r_q, r_rem, r_div;
    logic [rar_pkg::CNT_WIDTH-1:0] r_cnt;
    logic r_busy;
    logic [W:0] trial;

    // shift in next dividend bit and try subtracting
    assign trial = {r_rem, r_q[W-1]} - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= rar_pkg::CNT_WIDTH'(W);
            r_q    <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            if (!trial[W]) begin
                r_rem <= trial[W-1:0];
                r_q   <= {r_q[W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[W-2:0], r_q[W-1]};
                r_q   <= {r_q[W-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == rar_pkg::CNT_WIDTH'(1)) r_busy <= 1'b0;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule

// ===== verif/tb_top.sv =====
// Testbench for rational_arith_reduce: random and directed fraction requests,
// an in-order result scoreboard and randomized handshake gaps on both sides.
// Depends on rar_pkg and the rational_arith_reduce RTL.

class frac_scoreboard;
    rar_pkg::t_rsp pending[$];
    int            mismatches;

    // Euclid gcd helper on 64-bit longint magnitudes
    function automatic longint mag_gcd(longint x, longint y);
        longint t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic rar_pkg::t_rsp compute_fraction(rar_pkg::t_req r);
        rar_pkg::t_rsp e;
        longint a, b, c, d, n, m, g;
        a = r.first_num;
        b = r.first_den;
        c = r.second_num;
        d = r.second_den;
        e.result_num = 32'sd0;
        e.result_den = 32'sd1;
        if (b == 0 || d == 0) begin
            e.status = rar_pkg::ST_ZERODEN;
            return e;
        end
        if (r.action == rar_pkg::ACT_DIV && c == 0) begin
            e.status = rar_pkg::ST_DIVZERO;
            return e;
        end
        case (r.action)
            rar_pkg::ACT_ADD: begin n = a * d + c * b; m = b * d; end
            rar_pkg::ACT_SUB: begin n = a * d - c * b; m = b * d; end
            rar_pkg::ACT_MUL: begin n = a * c; m = b * d; end
            default:          begin n = a * d; m = b * c; end
        endcase
        g = mag_gcd(n < 0 ? -n : n, m < 0 ? -m : m);
        n = n / g;
        m = m / g;
        // low 32 bits, two's complement wrap
        e.result_num = n[31:0];
        e.result_den = m[31:0];
        e.status     = rar_pkg::ST_OK;
        return e;
    endfunction

    function void note_request(rar_pkg::t_req r);
        pending.push_back(compute_fraction(r));
    endfunction

    function void check_result(rar_pkg::t_rsp got);
        rar_pkg::t_rsp want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result num=%0d den=%0d st=%0d",
                         got.result_num, got.result_den, got.status);
            return;
        end
        want = pending.pop_front();
        if (got.result_num !== want.result_num || got.result_den !== want.result_den
                || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp %0d/%0d st=%0d got %0d/%0d st=%0d",
                         want.result_num, want.result_den, want.status,
                         got.result_num, got.result_den, got.status);
        end
    endfunction
endclass

module tb_top;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic o_ready, o_valid;
    rar_pkg::t_req i_req = '0;
    rar_pkg::t_rsp o_rsp;

    frac_scoreboard board = new();
    bit sending_done = 1'b0;

    rational_arith_reduce uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_req  (i_req),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_rsp  (o_rsp)
    );

    always #10 i_clk = ~i_clk;

    // mostly short gaps, occasionally a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    function automatic logic signed [15:0] rand_operand();
        int p;
        p = $urandom_range(0, 9);
        case (p)
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
            4, 5: return $signed(16'($urandom_range(0, 24))) - 16'sd12;
            default: return 16'($urandom);
        endcase
    endfunction

    // one request: optional idle gap, then hold valid until accepted
    task automatic send_request(rar_pkg::t_req r);
        int g;
        g = gap_len();
        @(negedge i_clk);
        if (g != 0) begin
            i_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_req   <= r;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        board.note_request(r);
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic send_fraction(logic [1:0] act, int a, int b, int c, int d);
        rar_pkg::t_req r;
        r.action     = act;
        r.first_num  = a[15:0];
        r.first_den  = b[15:0];
        r.second_num = c[15:0];
        r.second_den = d[15:0];
        send_request(r);
    endtask

    // result side: random stall on i_ready, sample at rising edge
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            g = gap_len();
            if (g != 0) begin
                i_ready <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            board.check_result(o_rsp);
        end
    end

    // stimulus
    initial begin
        rar_pkg::t_req r;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every operation, extremes, and each special case
        send_fraction(rar_pkg::ACT_ADD, 1, 2, 1, 3);
        send_fraction(rar_pkg::ACT_SUB, 1, 2, 1, 2);
        send_fraction(rar_pkg::ACT_MUL, 2, -4, 3, 9);
        send_fraction(rar_pkg::ACT_DIV, 5, 7, -10, 21);
        send_fraction(rar_pkg::ACT_ADD, 3, 0, 1, 1);
        send_fraction(rar_pkg::ACT_DIV, 1, 1, 4, 0);
        send_fraction(rar_pkg::ACT_DIV, 1, 2, 0, 5);
        send_fraction(rar_pkg::ACT_MUL, 0, -7, 5, 3);
        send_fraction(rar_pkg::ACT_ADD, 0, 5, 0, -3);
        send_fraction(rar_pkg::ACT_ADD, 32767, 32767, 32767, 32767);
        send_fraction(rar_pkg::ACT_SUB, -32767, 1, 32767, 1);
        send_fraction(rar_pkg::ACT_MUL, -32768, 1, -32768, 1);
        send_fraction(rar_pkg::ACT_ADD, -32768, 1, -32768, 1);
        send_fraction(rar_pkg::ACT_SUB, -32768, -32768, 32767, -32768);
        send_fraction(rar_pkg::ACT_DIV, -32768, 1, 1, -32768);
        send_fraction(rar_pkg::ACT_MUL, 32767, -32768, 32767, 32767);
        send_fraction(rar_pkg::ACT_ADD, 1, -32768, 1, 32767);
        send_fraction(rar_pkg::ACT_DIV, 0, 3, 0, 3);
        drop_valid();

        // pause until every expected result has come
        wait (board.pending.size() == 0);

        for (int k = 0; k < 1500; k++) begin
            r.action     = 2'($urandom_range(0, 3));
            r.first_num  = rand_operand();
            r.first_den  = rand_operand();
            r.second_num = rand_operand();
            r.second_den = rand_operand();
            send_request(r);
        end
        drop_valid();
        sending_done = 1'b1;
    end

    // end of run
    initial begin
        wait (sending_done);
        wait (board.pending.size() == 0);
        repeat (200) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // timeout: ~1520 requests with the longest stalls
    initial begin
        #400000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== filelist.f =====
src/rar_pkg.sv
src/rar_divu.sv
src/rational_arith_reduce.sv
verif/tb_top.sv
